/* hw/rtl/mactp_pkg.sv */
package mactp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned AddrW   = 48;
  localparam int unsigned PosW    = 5;
  localparam int unsigned NibbleW = 4;

  localparam logic [PosW-1:0] BareLen  = PosW'(12);
  localparam logic [PosW-1:0] DelimLen = PosW'(17);
  localparam logic [PosW-1:0] PosMax   = '1;

  localparam logic [CharW-1:0] CharNul = 8'h00;

  // Phase of a character inside a delimited byte group
  typedef enum logic [1:0] {
    PhHigh  = 2'd0,
    PhLow   = 2'd1,
    PhDelim = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ModeUndecided = 3'b001,
    ModeBare      = 3'b010,
    ModeDelim     = 3'b100
  } mode_e;

  typedef struct packed {
    logic             parse_ok;
    logic [AddrW-1:0] mac_address;
    logic             vendor_prefix_match;
  } result_t;

  function automatic logic is_hex(input logic [CharW-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [NibbleW-1:0] hex_val(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    return v[NibbleW-1:0];
  endfunction

  function automatic logic is_punct(input logic [CharW-1:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic logic vendor_match(input logic [AddrW-1:0] a);
    logic [15:0] oui;
    oui = a[39:24];
    return (a[47:40] == 8'h00) &&
           (oui == 16'h0569 || oui == 16'h0c29 || oui == 16'h1c14 || oui == 16'h5056);
  endfunction

endpackage

/* hw/rtl/mactp_char_if.sv */
interface mactp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

/* hw/rtl/mactp_result_if.sv */
interface mactp_result_if;
  logic        valid;
  logic        ready;
  logic        parse_ok;
  logic [47:0] mac_address;
  logic        vendor_prefix_match;

  modport source (output valid, output parse_ok, output mac_address,
                  output vendor_prefix_match, input ready);
  modport sink (input valid, input parse_ok, input mac_address,
                input vendor_prefix_match, output ready);
endinterface

/* hw/rtl/mac_address_text_parser.sv */
// MAC address text parser: feed the address text one character per transfer on in_i and end it
// with a NUL; each NUL yields one result on out_o (parse_ok, the stored 48-bit address, and a
// flag for four fixed vendor prefixes), other characters yield none. The per-character state
// update is a single compare-and-shift step, so a character can be accepted every cycle while
// in_i is ready. Results sit in an output register backed by one skid entry; in_i drops ready
// only while that skid entry is occupied. cfg_wdata_i, written with cfg_we_i, is the required
// delimiter (0 = detect from the third character or accept 12 bare digits); the stored value is
// used at the first character of each text; write it only while the block is idle.
module mac_address_text_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mactp_pkg::CharW-1:0] cfg_wdata_i,
  mactp_char_if.sink                 in_i,
  mactp_result_if.source             out_o
);
  import mactp_pkg::*;

  logic [CharW-1:0]   req_delim_q;
  logic [AddrW-1:0]   stored_q, stored_d;
  logic [AddrW-1:0]   partial_q, partial_d;
  logic [PosW-1:0]    pos_q, pos_d;
  phase_e             phase_q, phase_d;
  mode_e              mode_q, mode_d;
  logic [CharW-1:0]   delim_q, delim_d;
  logic               err_q, err_d;
  logic [NibbleW-1:0] hn_q, hn_d;

  result_t out_q, skid_q, res_new;
  logic    out_valid_q, skid_valid_q;

  logic [CharW-1:0] c;
  logic             accept, push, drain, ok;

  assign c      = in_i.char_code;
  assign accept = in_i.valid && in_i.ready;
  assign push   = accept && (c == CharNul);
  assign drain  = !out_valid_q || out_o.ready;
  assign in_i.ready = !skid_valid_q;

  assign ok = !err_q && ((mode_q == ModeBare && pos_q == BareLen) ||
                         (mode_q == ModeDelim && pos_q == DelimLen));

  always_comb begin
    logic take, first;
    stored_d  = stored_q;
    partial_d = partial_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    mode_d    = mode_q;
    delim_d   = delim_q;
    err_d     = err_q;
    hn_d      = hn_q;
    take      = 1'b0;
    first     = 1'b0;
    res_new   = '0;

    if (c == CharNul) begin
      if (ok) begin
        stored_d = partial_q;
      end
      res_new.parse_ok            = ok;
      res_new.mac_address         = stored_d;
      res_new.vendor_prefix_match = vendor_match(stored_d);
      partial_d = '0;
      pos_d     = '0;
      phase_d   = PhHigh;
      mode_d    = ModeUndecided;
      delim_d   = '0;
      err_d     = 1'b0;
      hn_d      = '0;
    end else begin
      if (pos_q != PosMax) begin
        pos_d = pos_q + PosW'(1);
      end
      case (phase_q)
        PhHigh:  phase_d = PhLow;
        PhLow:   phase_d = PhDelim;
        default: phase_d = PhHigh;
      endcase

      if (!err_q) begin
        // Required delimiter forces delimited mode at the first character
        if (pos_q == '0 && req_delim_q != '0) begin
          mode_d  = ModeDelim;
          delim_d = req_delim_q;
        end
        case (mode_d)
          ModeUndecided: begin
            if (pos_q < PosW'(2)) begin
              take  = 1'b1;
              first = (pos_q == '0);
            end else if (is_hex(c) || !is_punct(c)) begin
              mode_d = ModeBare;
              take   = 1'b1;
              first  = 1'b1;
            end else begin
              mode_d  = ModeDelim;
              delim_d = c;
            end
          end
          ModeBare: begin
            if (pos_q >= BareLen) begin
              err_d = 1'b1;
            end else begin
              take  = 1'b1;
              first = !pos_q[0];
            end
          end
          default: begin
            if (pos_q >= DelimLen) begin
              err_d = 1'b1;
            end else if (phase_q == PhDelim) begin
              if (c != delim_d) begin
                err_d = 1'b1;
              end
            end else begin
              take  = 1'b1;
              first = (phase_q == PhHigh);
            end
          end
        endcase

        if (take) begin
          if (!is_hex(c)) begin
            err_d = 1'b1;
          end else if (first) begin
            hn_d = hex_val(c);
          end else begin
            partial_d = {partial_q[AddrW-9:0], hn_q, hex_val(c)};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_delim_q <= '0;
    end else if (cfg_we_i) begin
      req_delim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q  <= '0;
      partial_q <= '0;
      pos_q     <= '0;
      phase_q   <= PhHigh;
      mode_q    <= ModeUndecided;
      delim_q   <= '0;
      err_q     <= 1'b0;
      hn_q      <= '0;
    end else if (accept) begin
      stored_q  <= stored_d;
      partial_q <= partial_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      mode_q    <= mode_d;
      delim_q   <= delim_d;
      err_q     <= err_d;
      hn_q      <= hn_d;
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (drain) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (push) begin
      skid_q <= res_new;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.parse_ok            = out_q.parse_ok;
  assign out_o.mac_address         = out_q.mac_address;
  assign out_o.vendor_prefix_match = out_q.vendor_prefix_match;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_nul_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (pos_q == '0 && mode_q == ModeUndecided && !err_q))
    else $error("text state not cleared after NUL");

  a_delim_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeDelim && !err_q) |-> (pos_q <= DelimLen))
    else $error("delimited text ran past its length without error");

  a_bare_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeBare && !err_q) |-> (pos_q <= BareLen))
    else $error("bare text ran past its length without error");

endmodule
